### rtl/gasp_pkg.sv
package gasp_pkg;

	localparam int GRID_W     = 16;
	localparam int GRID_H     = 16;
	localparam int CELLS      = GRID_W * GRID_H;
	localparam int CELL_BITS  = 8;
	localparam int SLOTS      = 64;
	localparam int SLOT_BITS  = 6;
	localparam int G_BITS     = 9;
	localparam int F_BITS     = 10;

	localparam logic [1:0] FUNC_CLEAR = 2'd0;
	localparam logic [1:0] FUNC_BLOCK = 2'd1;
	localparam logic [1:0] FUNC_SEARCH = 2'd2;
	localparam logic [1:0] FUNC_READ  = 2'd3;

	localparam logic [G_BITS-1:0] G_INF = '1;
	localparam logic [F_BITS-1:0] F_INF = '1;

	// One word of the per-cell score memory.
	typedef struct packed {
		logic                  pv;
		logic [3:0]            px;
		logic [3:0]            py;
		logic [G_BITS-1:0]     g;
		logic [F_BITS-1:0]     f;
	} cell_word_t;

	// Command from the sequencer to the score memory.
	typedef struct packed {
		logic                  rd;
		logic                  wr;
		logic [CELL_BITS-1:0]  addr;
		cell_word_t            wdata;
	} cell_cmd_t;

	// Absolute difference of two grid coordinates.
	function automatic logic [4:0] adiff(input logic [3:0] a, input logic [3:0] b);
		adiff = (a > b) ? {1'b0, a - b} : {1'b0, b - a};
	endfunction

endpackage

### rtl/gasp_cell_mem.sv
module gasp_cell_mem
	import gasp_pkg::*;
(
	input  logic       clk,
	input  cell_cmd_t  cmd,
	output cell_word_t rdata
);

	cell_word_t mem [CELLS];

	// One port: a write and a registered read share the address.
	always_ff @(posedge clk) begin
		if (cmd.wr) begin
			mem[cmd.addr] <= cmd.wdata;
		end
		if (cmd.rd) begin
			rdata <= mem[cmd.addr];
		end
	end

endmodule

### rtl/gasp_map_mem.sv
module gasp_map_mem
	import gasp_pkg::*;
(
	input  logic                 clk,
	input  logic                 wr,
	input  logic                 wdata,
	input  logic [CELL_BITS-1:0] waddr,
	input  logic [CELL_BITS-1:0] raddr,
	output logic                 rdata
);

	logic mem [CELLS];

	// Obstacle map: one write and one registered read a cycle.
	always_ff @(posedge clk) begin
		if (wr) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### rtl/grid_a_star_path_search.sv
// Grid A* path search.
// The slave channel (s_axis) carries one command a transfer: tdata holds
// func, node_x, node_y, goal_x and goal_y. The master channel (m_axis)
// returns exactly one result per command: found, open_overflow, pred_valid,
// pred_x and pred_y.
// Commands are handled one at a time. An obstacle write goes from the
// transfer straight to the output state; a predecessor read first passes
// the read wait and read done states. Clear map takes one sweep of the
// obstacle memory. A search opens with a sweep that sets every score word
// to infinite. Each expansion then scans all 64 open slots, loads the cell
// and reads each of its neighbors, plus a second slot scan for each
// neighbor whose cost improves. The slot scans and the single port of the
// score memory set the search time.
// After reset the block sweeps the obstacle map and the score memory
// before it takes its first command.
// A result waits in the output register while m_axis_tready is low; the
// next command is taken only when the result has been transferred.
module grid_a_star_path_search
	import gasp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// func[1:0], node_x[5:2], node_y[9:6], goal_x[13:10], goal_y[17:14], zero
	input  logic [23:0] s_axis_tdata,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// found[0], open_overflow[1], pred_valid[2], pred_x[6:3], pred_y[10:7], zero
	output logic [15:0] m_axis_tdata
);

	localparam logic [4:0] ST_INIT    = 5'd0;
	localparam logic [4:0] ST_IDLE    = 5'd1;
	localparam logic [4:0] ST_CLEAR   = 5'd2;
	localparam logic [4:0] ST_RDWAIT  = 5'd3;
	localparam logic [4:0] ST_RDDONE  = 5'd4;
	localparam logic [4:0] ST_SCLR    = 5'd5;
	localparam logic [4:0] ST_SCAN    = 5'd6;
	localparam logic [4:0] ST_SCAN2   = 5'd7;
	localparam logic [4:0] ST_PICK    = 5'd8;
	localparam logic [4:0] ST_CUR     = 5'd9;
	localparam logic [4:0] ST_CUR2    = 5'd10;
	localparam logic [4:0] ST_NB      = 5'd11;
	localparam logic [4:0] ST_NB2     = 5'd12;
	localparam logic [4:0] ST_NB3     = 5'd13;
	localparam logic [4:0] ST_PRES    = 5'd14;
	localparam logic [4:0] ST_DONE    = 5'd15;
	localparam logic [4:0] ST_OUT     = 5'd16;
	localparam logic [4:0] ST_START   = 5'd17;

	logic [4:0] state_q;
	logic [1:0] func_q;
	logic [3:0] nx_q, ny_q, gx_q, gy_q, cx_q, cy_q, tx_q, ty_q;
	logic [CELL_BITS:0] cnt_q;
	logic [1:0] dir_q;
	logic ovf_q, found_q;
	logic [10:0] res_q;
	logic out_v_q;
	logic [G_BITS-1:0] cg_q;

	// Open slots: valid flags in flip-flops, cell numbers in a memory.
	logic [SLOTS-1:0] sv_q;
	logic [CELL_BITS-1:0] slot_mem [SLOTS];
	logic [CELL_BITS-1:0] slot_rd;
	logic [SLOT_BITS-1:0] slot_raddr;
	logic slot_wr;
	logic [SLOT_BITS-1:0] slot_waddr;
	logic [CELL_BITS-1:0] slot_wdata;

	// Scan bookkeeping.
	logic [SLOT_BITS-1:0] scan_slot_s1;
	logic scan_v_s1;
	logic any_q, pres_q, free_any_q;
	logic [F_BITS-1:0] best_f_q;
	logic [SLOT_BITS-1:0] best_q, free_q;

	cell_cmd_t cmd;
	cell_word_t crd;
	logic map_wr, map_wd, map_rd;
	logic [CELL_BITS-1:0] map_waddr, map_raddr;

	gasp_cell_mem u_cell (.clk(clk), .cmd(cmd), .rdata(crd));
	gasp_map_mem u_map (.clk(clk), .wr(map_wr), .wdata(map_wd), .waddr(map_waddr),
		.raddr(map_raddr), .rdata(map_rd));

	always_ff @(posedge clk) begin
		if (slot_wr) begin
			slot_mem[slot_waddr] <= slot_wdata;
		end
		slot_rd <= slot_mem[slot_raddr];
	end

	// Current score word; every word is reset by the sweep at search start.
	cell_word_t cur_w;
	assign cur_w = crd;

	// Neighbor coordinates in the order x-1, x+1, y+1, y-1.
	logic nb_ok;
	logic [3:0] nbx, nby;
	always_comb begin
		nbx = cx_q;
		nby = cy_q;
		nb_ok = 1'b1;
		case (dir_q)
			2'd0: begin
				nbx = cx_q - 4'd1;
				nb_ok = (cx_q != 4'd0);
			end
			2'd1: begin
				nbx = cx_q + 4'd1;
				nb_ok = (cx_q != 4'(GRID_W - 1));
			end
			2'd2: begin
				nby = cy_q + 4'd1;
				nb_ok = (cy_q != 4'(GRID_H - 1));
			end
			default: begin
				nby = cy_q - 4'd1;
				nb_ok = (cy_q != 4'd0);
			end
		endcase
	end

	logic [G_BITS-1:0] newg;
	assign newg = cg_q + G_BITS'(1);

	// Memory port control.
	always_comb begin
		cmd = '0;
		map_wr = 1'b0;
		map_wd = 1'b0;
		map_waddr = cnt_q[CELL_BITS-1:0];
		map_raddr = {nbx, nby};
		slot_raddr = cnt_q[SLOT_BITS-1:0];
		slot_wr = 1'b0;
		slot_waddr = free_q;
		slot_wdata = {tx_q, ty_q};
		case (state_q)
			ST_INIT: begin
				map_wr = 1'b1;
				cmd.wr = 1'b1;
				cmd.addr = cnt_q[CELL_BITS-1:0];
				cmd.wdata.g = G_INF;
				cmd.wdata.f = F_INF;
			end
			ST_CLEAR: begin
				map_wr = 1'b1;
			end
			ST_IDLE: begin
				cmd.rd = 1'b1;
				cmd.addr = {s_axis_tdata[5:2], s_axis_tdata[9:6]};
				map_wr = s_axis_tvalid && s_axis_tready && (s_axis_tdata[1:0] == FUNC_BLOCK);
				map_wd = 1'b1;
				map_waddr = {s_axis_tdata[5:2], s_axis_tdata[9:6]};
			end
			ST_SCLR: begin
				cmd.wr = 1'b1;
				cmd.addr = cnt_q[CELL_BITS-1:0];
				cmd.wdata.g = G_INF;
				cmd.wdata.f = F_INF;
			end
			ST_START: begin
				cmd.wr = 1'b1;
				cmd.addr = {nx_q, ny_q};
				cmd.wdata.g = '0;
				cmd.wdata.f = F_BITS'(adiff(nx_q, gx_q)) + F_BITS'(adiff(ny_q, gy_q));
				slot_wr = 1'b1;
				slot_waddr = '0;
				slot_wdata = {nx_q, ny_q};
			end
			ST_SCAN: begin
				cmd.rd = 1'b1;
				cmd.addr = slot_rd;
			end
			ST_CUR: begin
				cmd.rd = 1'b1;
				cmd.addr = {cx_q, cy_q};
			end
			ST_NB: begin
				cmd.rd = 1'b1;
				cmd.addr = {nbx, nby};
			end
			ST_NB2: begin
				if (!map_rd && newg < cur_w.g) begin
					cmd.wr = 1'b1;
					cmd.addr = {nbx, nby};
					cmd.wdata.pv = 1'b1;
					cmd.wdata.px = cx_q;
					cmd.wdata.py = cy_q;
					cmd.wdata.g = newg;
					cmd.wdata.f = F_BITS'(newg) + F_BITS'(adiff(nbx, gx_q))
						+ F_BITS'(adiff(nby, gy_q));
				end
			end
			ST_DONE: begin
				slot_wr = !pres_q && free_any_q;
			end
			default: begin
			end
		endcase
	end

	// Slot scan pipeline: slot address, then slot data, then score word.
	logic scan_v_s2;
	logic [SLOT_BITS-1:0] scan_slot_s2;
	logic [CELL_BITS-1:0] scan_cell_s2;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_v_s1 <= 1'b0;
			scan_v_s2 <= 1'b0;
		end else begin
			scan_v_s1 <= (state_q == ST_SCAN || state_q == ST_PRES) && !cnt_q[SLOT_BITS];
			scan_v_s2 <= scan_v_s1 && state_q == ST_SCAN;
		end
	end
	always_ff @(posedge clk) begin
		scan_slot_s1 <= cnt_q[SLOT_BITS-1:0];
		scan_slot_s2 <= scan_slot_s1;
		scan_cell_s2 <= slot_rd;
	end

	logic [CELL_BITS-1:0] txy;
	assign txy = {tx_q, ty_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
			cnt_q <= '0;
			ovf_q <= 1'b0;
			out_v_q <= 1'b0;
			sv_q <= '0;
			dir_q <= '0;
			found_q <= 1'b0;
			any_q <= 1'b0;
			pres_q <= 1'b0;
			free_any_q <= 1'b0;
		end else begin
			if (out_v_q && m_axis_tready) begin
				out_v_q <= 1'b0;
			end
			case (state_q)
				ST_INIT: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == (CELL_BITS+1)'(CELLS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (s_axis_tvalid && s_axis_tready) begin
						func_q <= s_axis_tdata[1:0];
						nx_q <= s_axis_tdata[5:2];
						ny_q <= s_axis_tdata[9:6];
						gx_q <= s_axis_tdata[13:10];
						gy_q <= s_axis_tdata[17:14];
						cnt_q <= '0;
						case (s_axis_tdata[1:0])
							FUNC_CLEAR: state_q <= ST_CLEAR;
							FUNC_BLOCK: state_q <= ST_OUT;
							FUNC_READ: state_q <= ST_RDWAIT;
							default: begin
								state_q <= ST_SCLR;
								ovf_q <= 1'b0;
								found_q <= 1'b0;
							end
						endcase
					end
				end
				ST_CLEAR: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == (CELL_BITS+1)'(CELLS - 1)) begin
						state_q <= ST_OUT;
					end
				end
				ST_RDWAIT: begin
					state_q <= ST_RDDONE;
				end
				ST_RDDONE: begin
					state_q <= ST_OUT;
				end
				ST_SCLR: begin
					// Sweep every score word back to infinite.
					sv_q <= '0;
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == (CELL_BITS+1)'(CELLS - 1)) begin
						state_q <= ST_START;
					end
				end
				ST_START: begin
					sv_q[0] <= 1'b1;
					cnt_q <= '0;
					any_q <= 1'b0;
					state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					if (!cnt_q[SLOT_BITS]) begin
						cnt_q <= cnt_q + 1'b1;
					end
					if (scan_v_s2 && sv_q[scan_slot_s2]) begin
						if (!any_q || cur_w.f <= best_f_q) begin
							best_f_q <= cur_w.f;
							best_q <= scan_slot_s2;
							cx_q <= scan_cell_s2[7:4];
							cy_q <= scan_cell_s2[3:0];
							any_q <= 1'b1;
						end
					end
					if (cnt_q[SLOT_BITS] && !scan_v_s1 && !scan_v_s2) begin
						state_q <= ST_PICK;
					end
				end
				ST_PICK: begin
					if (!any_q) begin
						state_q <= ST_OUT;
					end else begin
						sv_q[best_q] <= 1'b0;
						if (cx_q == gx_q && cy_q == gy_q) begin
							found_q <= 1'b1;
							state_q <= ST_OUT;
						end else begin
							state_q <= ST_CUR;
						end
					end
				end
				ST_CUR: begin
					state_q <= ST_CUR2;
				end
				ST_CUR2: begin
					cg_q <= cur_w.g;
					dir_q <= '0;
					state_q <= ST_NB;
				end
				ST_NB: begin
					if (nb_ok) begin
						state_q <= ST_NB2;
					end else begin
						state_q <= ST_NB3;
					end
				end
				ST_NB2: begin
					if (!map_rd && newg < cur_w.g) begin
						tx_q <= nbx;
						ty_q <= nby;
						cnt_q <= '0;
						pres_q <= 1'b0;
						free_any_q <= 1'b0;
						state_q <= ST_PRES;
					end else begin
						state_q <= ST_NB3;
					end
				end
				ST_PRES: begin
					// Presence check and lowest free slot search.
					if (!cnt_q[SLOT_BITS]) begin
						cnt_q <= cnt_q + 1'b1;
					end
					if (scan_v_s1) begin
						if (sv_q[scan_slot_s1] && slot_rd == txy) begin
							pres_q <= 1'b1;
						end
						if (!sv_q[scan_slot_s1] && !free_any_q) begin
							free_any_q <= 1'b1;
							free_q <= scan_slot_s1;
						end
					end
					if (cnt_q[SLOT_BITS] && !scan_v_s1) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (!pres_q) begin
						if (free_any_q) begin
							sv_q[free_q] <= 1'b1;
						end else begin
							ovf_q <= 1'b1;
						end
					end
					state_q <= ST_NB3;
				end
				ST_NB3: begin
					dir_q <= dir_q + 2'd1;
					if (dir_q == 2'd3) begin
						cnt_q <= '0;
						any_q <= 1'b0;
						state_q <= ST_SCAN;
					end else begin
						state_q <= ST_NB;
					end
				end
				ST_OUT: begin
					if (!out_v_q) begin
						out_v_q <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Result word assembly.
	always_ff @(posedge clk) begin
		if (state_q == ST_RDDONE) begin
			res_q <= {cur_w.pv ? cur_w.py : 4'd0, cur_w.pv ? cur_w.px : 4'd0, cur_w.pv, 2'b00};
		end else if (state_q == ST_IDLE && !out_v_q) begin
			res_q <= '0;
		end else if (state_q == ST_OUT && !out_v_q) begin
			res_q[1:0] <= {ovf_q, found_q && func_q == FUNC_SEARCH};
		end
	end

	// Read data for the query is held across the response wait.
	assign s_axis_tready = (state_q == ST_IDLE) && !out_v_q;
	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata = {5'd0, res_q};

endmodule

### rtl/gasp_checker.sv
module gasp_checker
	import gasp_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic [23:0] s_axis_tdata,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [15:0] m_axis_tdata
);

	// A result stays until it is transferred.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result dropped while stalled");

	// No command is taken while a result waits.
	a_one: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !s_axis_tready)
		else $error("command taken while result pending");

	// Predecessor fields are zero unless valid.
	a_pred: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tdata[2] |-> m_axis_tdata[10:3] == 8'd0)
		else $error("predecessor without valid");

	// A command transfer never yields a result in the next cycle.
	a_lat: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !m_axis_tvalid)
		else $error("result too early");

endmodule

bind grid_a_star_path_search gasp_checker u_gasp_checker (.*);

### sim/grid_a_star_path_search_tb.sv
module grid_a_star_path_search_tb;
	import gasp_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	// One command as it travels on the slave channel.
	typedef struct packed {
		logic [3:0] goal_y;
		logic [3:0] goal_x;
		logic [3:0] node_y;
		logic [3:0] node_x;
		logic [1:0] func;
	} cmd_t;

	// One result as it travels on the master channel.
	typedef struct packed {
		logic [3:0] pred_y;
		logic [3:0] pred_x;
		logic       pred_valid;
		logic       open_overflow;
		logic       found;
	} rsp_t;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [23:0] s_axis_tdata;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [15:0] m_axis_tdata;

	// Predictor state: obstacle map, search scores, predecessors, open list.
	logic        blk_map [CELLS];
	int unsigned g_score [CELLS];
	int unsigned f_score [CELLS];
	logic        par_ok [CELLS];
	logic [3:0]  par_x [CELLS];
	logic [3:0]  par_y [CELLS];
	logic        slot_ok [SLOTS];
	logic [3:0]  slot_x [SLOTS];
	logic [3:0]  slot_y [SLOTS];
	logic        ovf_seen;

	rsp_t        expected_rsps[$];
	int          error_count;
	bit          send_gaps;
	bit          recv_gaps;
	int          recv_hold;
	bit          sink_done;

	grid_a_star_path_search u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int idx(input int x, input int y);
		return x * GRID_H + y;
	endfunction

	function automatic int unsigned manh(input int ax, input int ay, input int bx, input int by);
		return ((ax > bx) ? ax - bx : bx - ax) + ((ay > by) ? ay - by : by - ay);
	endfunction

	// Relax one neighbor of the cell being expanded.
	function automatic void relax_cell(input int nx, input int ny, input int cx, input int cy,
			input int gx, input int gy);
		int n;
		int unsigned g;
		bit present;
		if (nx < 0 || ny < 0 || nx >= GRID_W || ny >= GRID_H)
			return;
		n = idx(nx, ny);
		if (blk_map[n])
			return;
		g = g_score[idx(cx, cy)] + 1;
		if (!(g < g_score[n]))
			return;
		par_ok[n] = 1'b1;
		par_x[n] = cx[3:0];
		par_y[n] = cy[3:0];
		g_score[n] = g;
		f_score[n] = g + manh(nx, ny, gx, gy);
		present = 0;
		for (int i = 0; i < SLOTS; i++)
			if (slot_ok[i] && slot_x[i] == nx[3:0] && slot_y[i] == ny[3:0])
				present = 1;
		if (present)
			return;
		for (int i = 0; i < SLOTS; i++) begin
			if (!slot_ok[i]) begin
				slot_ok[i] = 1'b1;
				slot_x[i] = nx[3:0];
				slot_y[i] = ny[3:0];
				return;
			end
		end
		ovf_seen = 1'b1;
	endfunction

	function automatic void wipe_search();
		for (int i = 0; i < CELLS; i++) begin
			g_score[i] = 32'hFFFF_FFFF;
			f_score[i] = 32'hFFFF_FFFF;
			par_ok[i] = 1'b0;
			par_x[i] = '0;
			par_y[i] = '0;
		end
		for (int i = 0; i < SLOTS; i++) begin
			slot_ok[i] = 1'b0;
			slot_x[i] = '0;
			slot_y[i] = '0;
		end
		ovf_seen = 1'b0;
	endfunction

	// Full A* search over the predictor state; returns whether the goal was reached.
	function automatic bit search_path(input int sx, input int sy, input int gx, input int gy);
		int best, cx, cy;
		int unsigned best_f, f;
		bit any;
		wipe_search();
		slot_ok[0] = 1'b1;
		slot_x[0] = sx[3:0];
		slot_y[0] = sy[3:0];
		g_score[idx(sx, sy)] = 0;
		f_score[idx(sx, sy)] = manh(sx, sy, gx, gy);
		forever begin
			any = 0;
			best = 0;
			best_f = 32'hFFFF_FFFF;
			for (int i = 0; i < SLOTS; i++) begin
				if (slot_ok[i]) begin
					f = f_score[idx(slot_x[i], slot_y[i])];
					if (!any || f <= best_f) begin
						best_f = f;
						best = i;
						any = 1;
					end
				end
			end
			if (!any)
				return 0;
			cx = slot_x[best];
			cy = slot_y[best];
			slot_ok[best] = 1'b0;
			if (cx == gx && cy == gy)
				return 1;
			relax_cell(cx - 1, cy, cx, cy, gx, gy);
			relax_cell(cx + 1, cy, cx, cy, gx, gy);
			relax_cell(cx, cy + 1, cx, cy, gx, gy);
			relax_cell(cx, cy - 1, cx, cy, gx, gy);
		end
	endfunction

	// Work out the result of one command and update the predictor state.
	function automatic rsp_t predict_rsp(input cmd_t c);
		rsp_t r;
		int n;
		r = '0;
		n = idx(c.node_x, c.node_y);
		case (c.func)
			FUNC_CLEAR: begin
				for (int i = 0; i < CELLS; i++)
					blk_map[i] = 1'b0;
			end
			FUNC_BLOCK: begin
				blk_map[n] = 1'b1;
			end
			FUNC_SEARCH: begin
				r.found = search_path(c.node_x, c.node_y, c.goal_x, c.goal_y);
			end
			default: begin
				if (par_ok[n]) begin
					r.pred_valid = 1'b1;
					r.pred_x = par_x[n];
					r.pred_y = par_y[n];
				end
			end
		endcase
		r.open_overflow = ovf_seen;
		return r;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("mismatch %s: got %0d expected %0d", what, got, want);
		error_count++;
	endtask

	// Send one command and queue its expected result on transfer.
	task automatic send_cmd(input logic [1:0] func, input int nx, input int ny,
			input int gx, input int gy);
		cmd_t c;
		c.func = func;
		c.node_x = nx[3:0];
		c.node_y = ny[3:0];
		c.goal_x = gx[3:0];
		c.goal_y = gy[3:0];
		while (send_gaps && $urandom_range(99) < 32) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {6'd0, c};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		expected_rsps.push_back(predict_rsp(c));
		@(negedge clk);
	endtask

	// Stop offering commands and wait for every expected result.
	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		while (expected_rsps.size() != 0)
			@(negedge clk);
	endtask

	// Result checker: compares each transfer with the oldest expectation.
	always @(posedge clk) begin
		rsp_t got, want;
		if (m_axis_tvalid && m_axis_tready) begin
			got = m_axis_tdata[10:0];
			if (expected_rsps.size() == 0) begin
				report_mismatch("unexpected result", m_axis_tdata, 0);
			end else begin
				want = expected_rsps.pop_front();
				if (got.found !== want.found)
					report_mismatch("found", got.found, want.found);
				if (got.open_overflow !== want.open_overflow)
					report_mismatch("open_overflow", got.open_overflow, want.open_overflow);
				if (got.pred_valid !== want.pred_valid)
					report_mismatch("pred_valid", got.pred_valid, want.pred_valid);
				if (got.pred_x !== want.pred_x)
					report_mismatch("pred_x", got.pred_x, want.pred_x);
				if (got.pred_y !== want.pred_y)
					report_mismatch("pred_y", got.pred_y, want.pred_y);
				if (m_axis_tdata[15:11] !== '0)
					report_mismatch("pad", m_axis_tdata[15:11], 0);
			end
		end
	end

	// Receiver ready: random stalls, or a counted hold-off when asked.
	always @(negedge clk) begin
		if (recv_hold > 0) begin
			m_axis_tready <= 1'b0;
			recv_hold <= recv_hold - 1;
		end else begin
			m_axis_tready <= !(recv_gaps && $urandom_range(99) < 32);
		end
	end

	task automatic test_directed();
		send_cmd(FUNC_READ, 0, 0, 0, 0);
		send_cmd(FUNC_SEARCH, 0, 0, 0, 0);
		send_cmd(FUNC_SEARCH, 0, 0, 15, 15);
		send_cmd(FUNC_READ, 15, 15, 0, 0);
		send_cmd(FUNC_READ, 0, 1, 0, 0);
		send_cmd(FUNC_READ, 0, 0, 0, 0);
		// Wall across x = 8 with one gap, then search through it.
		for (int y = 0; y < 15; y++)
			send_cmd(FUNC_BLOCK, 8, y, 0, 0);
		send_cmd(FUNC_SEARCH, 15, 0, 0, 0);
		send_cmd(FUNC_READ, 8, 15, 0, 0);
		// Blocked start still expands and reaches the gap.
		send_cmd(FUNC_SEARCH, 8, 0, 8, 15);
		send_cmd(FUNC_CLEAR, 0, 0, 0, 0);
		send_cmd(FUNC_READ, 15, 0, 15, 15);
	endtask

	// Random item: mostly blocks and reads, some searches to random goals, a few clears.
	task automatic random_cmd();
		int r, nx, ny;
		r = $urandom_range(99);
		nx = $urandom_range(15);
		ny = $urandom_range(15);
		if (r < 40)
			send_cmd(FUNC_BLOCK, nx, ny, $urandom_range(15), $urandom_range(15));
		else if (r < 70)
			send_cmd(FUNC_READ, nx, ny, $urandom_range(15), $urandom_range(15));
		else if (r < 95)
			send_cmd(FUNC_SEARCH, nx, ny, $urandom_range(15), $urandom_range(15));
		else
			send_cmd(FUNC_CLEAR, nx, ny, $urandom_range(15), $urandom_range(15));
	endtask

	task automatic test_random();
		send_gaps = 1;
		recv_gaps = 1;
		for (int i = 0; i < 70; i++)
			random_cmd();
		wait_drained();
	endtask

	task automatic test_backpressure();
		recv_hold <= 300;
		for (int i = 0; i < 6; i++)
			send_cmd(FUNC_READ, $urandom_range(15), $urandom_range(15), 0, 0);
		wait_drained();
	endtask

	initial begin
		error_count = 0;
		send_gaps = 0;
		recv_gaps = 0;
		recv_hold = 0;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		m_axis_tready = 1'b0;
		for (int i = 0; i < CELLS; i++)
			blk_map[i] = 1'b0;
		wipe_search();
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_directed();
		wait_drained();
		test_random();
		test_backpressure();
		repeat (200) @(negedge clk);
		if (error_count == 0 && expected_rsps.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	// Timeout well above the slowest run of every search.
	initial begin
		#200ms;
		$display("TB_ERROR");
		$finish;
	end

endmodule
